// ----- src/ifc_pkg.sv -----
// Shared types and constants for the information frame checker.
`timescale 1ns / 1ps

package ifc_pkg;

    localparam logic [7:0] SC_END   = 8'hff;
    localparam logic [7:0] FRAME_ID = 8'hd5;
    localparam logic [7:0] LEN_MIN  = 8'd2;
    localparam logic [7:0] LEN_MAX  = 8'd254;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_LCHK  = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_ID    = 3'd4;
    localparam logic [2:0] ST_DCHK  = 3'd5;
    localparam logic [2:0] ST_REPLY = 3'd6;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       start_req;
        logic [7:0] cmd_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       frame_end;
        logic [2:0] status;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_res_t;

endpackage

// ----- src/ifc_chan_if.sv -----
// Valid/ready channel carrying one item per handshake.
`timescale 1ns / 1ps

interface ifc_chan_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/info_frame_checker_core.sv -----
// Top level of the information frame checker.
//
//  channel   dir   payload
//  rx_chan   in    rx_byte, start_req, cmd_code
//  res_chan  out   data_byte, data_valid, frame_end, status
//
// One byte per cycle while the result channel is ready; each item passes
// the input register and check logic; results enter the result register.
// Reset clears the parse position to idle and all frame state to zero.
// A stalled result register holds the check stage; the input register
// then takes a new item only while it is empty.
`timescale 1ns / 1ps

module info_frame_checker_core
    import ifc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ifc_chan_if.sink   rx_chan,
    ifc_chan_if.source res_chan
);

    logic      item_valid;
    in_item_t  item;
    logic      take;
    logic      out_free;
    step_res_t res;

    ifc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_chan    (rx_chan),
        .drain      (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ifc_frame_step u_frame_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res        (res)
    );

    ifc_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .res      (res),
        .out_free (out_free),
        .res_chan (res_chan)
    );

endmodule

// ----- src/ifc_in_stage.sv -----
// Input register for received bytes.
`timescale 1ns / 1ps

module ifc_in_stage
    import ifc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ifc_chan_if.sink rx_chan,
    input  logic     drain,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign rx_chan.ready = !valid_reg || drain;
    assign valid_next    = rx_chan.valid || (valid_reg && !drain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx_chan.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_chan.ready && rx_chan.valid)
        begin
            item_reg <= rx_chan.payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- src/ifc_frame_step.sv -----
// Frame parsing state and per-item check logic.
`timescale 1ns / 1ps

module ifc_frame_step
    import ifc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  in_item_t  item,
    input  logic      out_free,
    output logic      take,
    output step_res_t res
);

    localparam logic [8:0] POS_IDLE = 9'd0;
    localparam logic [8:0] POS_SC0  = 9'd1;
    localparam logic [8:0] POS_SC1  = 9'd2;
    localparam logic [8:0] POS_SC2  = 9'd3;
    localparam logic [8:0] POS_LEN  = 9'd4;
    localparam logic [8:0] POS_LCS  = 9'd5;
    localparam logic [8:0] POS_TFI  = 9'd6;
    localparam logic [8:0] POS_DATA = 9'd7;

    logic [8:0] pos_reg;
    logic [8:0] pos_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] exp_reg;
    logic [7:0] exp_next;
    logic       mism_reg;
    logic       mism_next;

    logic [7:0] b;
    logic [7:0] len_chk;
    logic [7:0] sum_chk;
    logic [8:0] data_end;
    logic       close;
    logic [2:0] close_code;

    assign take     = item_valid && out_free;
    assign b        = item.rx_byte;
    assign len_chk  = len_reg + b;
    assign sum_chk  = sum_reg + b;
    assign data_end = {1'b0, len_reg} + 9'd6;

    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        exp_next   = exp_reg;
        mism_next  = mism_reg;
        close      = 1'b0;
        close_code = ST_OK;
        res        = '0;

        if (item.start_req)
        begin
            exp_next  = item.cmd_code + 8'd1;
            sum_next  = 8'd0;
            mism_next = 1'b0;
            len_next  = 8'd0;
            pos_next  = POS_SC0;
        end
        else
        begin
            case (pos_reg)
                POS_IDLE:
                begin
                    pos_next = POS_IDLE;
                end
                POS_SC0, POS_SC1:
                begin
                    if (b != 8'd0)
                    begin
                        close      = 1'b1;
                        close_code = ST_START;
                    end
                    else
                    begin
                        pos_next = pos_reg + 9'd1;
                    end
                end
                POS_SC2:
                begin
                    if (b != SC_END)
                    begin
                        close      = 1'b1;
                        close_code = ST_START;
                    end
                    else
                    begin
                        pos_next = POS_LEN;
                    end
                end
                POS_LEN:
                begin
                    len_next = b;
                    pos_next = POS_LCS;
                end
                POS_LCS:
                begin
                    if (len_chk != 8'd0)
                    begin
                        close      = 1'b1;
                        close_code = ST_LCHK;
                    end
                    else if (!(len_reg inside {[LEN_MIN:LEN_MAX]}))
                    begin
                        close      = 1'b1;
                        close_code = ST_RANGE;
                    end
                    else
                    begin
                        pos_next = POS_TFI;
                    end
                end
                POS_TFI:
                begin
                    if (b != FRAME_ID)
                    begin
                        close      = 1'b1;
                        close_code = ST_ID;
                    end
                    else
                    begin
                        sum_next = b;
                        pos_next = POS_DATA;
                    end
                end
                default:
                begin
                    if (pos_reg < data_end)
                    begin
                        if (pos_reg == POS_DATA && b != exp_reg)
                        begin
                            mism_next = 1'b1;
                        end
                        sum_next                 = sum_chk;
                        pos_next                 = pos_reg + 9'd1;
                        res.valid                = 1'b1;
                        res.item.data_byte       = b;
                        res.item.data_valid      = 1'b1;
                    end
                    else
                    begin
                        close = 1'b1;
                        if (sum_chk != 8'd0)
                        begin
                            close_code = ST_DCHK;
                        end
                        else if (mism_reg)
                        begin
                            close_code = ST_REPLY;
                        end
                        else
                        begin
                            close_code = ST_OK;
                        end
                    end
                end
            endcase
        end

        if (close)
        begin
            pos_next           = POS_IDLE;
            res.valid          = 1'b1;
            res.item.frame_end = 1'b1;
            res.item.status    = close_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_IDLE;
            len_reg  <= 8'd0;
            sum_reg  <= 8'd0;
            exp_reg  <= 8'd0;
            mism_reg <= 1'b0;
        end
        else if (take)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            sum_reg  <= sum_next;
            exp_reg  <= exp_next;
            mism_reg <= mism_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 9'd260)
        else $error("position beyond last check byte");

    a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && res.valid && res.item.frame_end |=> pos_reg == POS_IDLE)
        else $error("closing result did not return to idle");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.item.data_valid ^ res.item.frame_end))
        else $error("result is neither payload nor close, or both");

    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.start_req |=> pos_reg == POS_SC0)
        else $error("start did not reset position");
`endif

endmodule

// ----- src/ifc_out_stage.sv -----
// Result register driving the output channel.
`timescale 1ns / 1ps

module ifc_out_stage
    import ifc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  step_res_t  res,
    output logic       out_free,
    ifc_chan_if.source res_chan
);

    logic      valid_reg;
    logic      valid_next;
    logic      load;
    out_item_t item_reg;

    assign load       = take && res.valid;
    assign out_free   = !valid_reg || res_chan.ready;
    assign valid_next = load || (valid_reg && !res_chan.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= res.item;
        end
    end

    assign res_chan.valid   = valid_reg;
    assign res_chan.payload = item_reg;

endmodule
